// File: rtl/c2d_pkg.sv
`default_nettype none
package c2d_pkg;

    localparam int KSIZE     = 5;
    localparam int RAD       = KSIZE / 2;
    localparam int LINES     = KSIZE - 1;
    localparam int PIX_BITS  = 10;
    localparam int COEF_BITS = 12;
    localparam int CFG_BITS  = 60;
    localparam int FSIZE_BITS = 12;   // width of the frame size write field
    localparam int SHIFT_BITS = 5;
    localparam int ROW_BITS  = 12;    // input row counter, saturates
    localparam int SIZE_BITS = 14;    // effective sizes up to 16383
    localparam int PROD_BITS = PIX_BITS + 1 + COEF_BITS;
    localparam int RSUM_BITS = PROD_BITS + 3;
    localparam int SUM_BITS  = RSUM_BITS + 3;

    localparam logic [ROW_BITS-1:0] ROW_SAT = {ROW_BITS{1'b1}};
    localparam logic [PIX_BITS-1:0] PIX_MAX = 10'h3ff;

    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_SHIFT  = 3'd2,
        REG_COEF0  = 3'd3,
        REG_COEF1  = 3'd4,
        REG_COEF2  = 3'd5,
        REG_COEF3  = 3'd6,
        REG_COEF4  = 3'd7
    } cfg_reg_t;

    typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_BITS-1:0]  win_t;
    typedef logic [KSIZE-1:0][KSIZE-1:0][COEF_BITS-1:0] kern_t;

    typedef struct packed {
        win_t             win;
        logic [KSIZE-1:0] row_ok;
        logic [KSIZE-1:0] col_ok;
        logic             done;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage
`default_nettype wire

// File: rtl/c2d_ram.sv
`default_nettype none
module c2d_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/c2d_front.sv
`default_nettype none
module c2d_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [c2d_pkg::PIX_BITS-1:0]          pixel_in,
    input  wire logic                                  flush,
    input  wire logic [c2d_pkg::FSIZE_BITS:0]          frame_width,
    input  wire logic [c2d_pkg::FSIZE_BITS:0]          frame_height,
    input  wire c2d_pkg::q_stat_t                      q_stat,
    output logic                                       q_push,
    output c2d_pkg::item_t                             q_item,
    output logic                                       clr_busy
);

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int HB = $clog2(MAX_HEIGHT);
    localparam int SB = c2d_pkg::SIZE_BITS;
    localparam int PB = c2d_pkg::ROW_BITS + SB + 1;
    localparam int K  = c2d_pkg::KSIZE;
    localparam int PW = c2d_pkg::PIX_BITS;
    localparam int LW = c2d_pkg::LINES * PW;
    localparam logic [SB-1:0] WMAX = SB'(MAX_WIDTH);
    localparam logic [SB-1:0] HMAX = SB'(MAX_HEIGHT);
    localparam logic [CB-1:0] CLR_LAST = CB'(MAX_WIDTH - 1);

    logic                      clr_busy_reg;
    logic [CB-1:0]             clr_cnt_reg;
    logic [CB-1:0]             in_col_reg, in_col_next;
    logic [c2d_pkg::ROW_BITS-1:0] in_row_reg, in_row_next;
    logic [CB-1:0]             out_col_reg, out_col_next;
    logic [HB-1:0]             out_row_reg, out_row_next;

    logic                      a_valid_reg;
    logic [PW-1:0]             a_pix_reg;
    logic [CB-1:0]             a_addr_reg;
    logic                      a_emit_reg;
    logic                      a_done_reg;
    logic [K-1:0]              a_row_ok_reg, a_col_ok_reg;
    logic                      fwd_hit_reg;
    logic [LW-1:0]             fwd_data_reg;
    c2d_pkg::win_t             win_reg, win_next;

    logic [SB-1:0]             w, h, ic, oc, ic1, oc1, orow1;
    logic [PB-1:0]             pos, thresh;
    logic                      accept, a_fire, emit, done, col_wrap, out_wrap, last_row;
    logic [K-1:0]              row_ok, col_ok;
    logic [SB:0]               tr, tc;
    logic [LW-1:0]             ram_q, line, line_wr;
    logic [K-1:0][PW-1:0]      col;
    logic                      ram_we;
    logic [CB-1:0]             ram_waddr;
    logic [LW-1:0]             ram_wdata;

    // effective frame size, saturated to 1..MAX
    always_comb
    begin
        if (frame_width == '0)
            w = SB'(1);
        else if (SB'(frame_width) > WMAX)
            w = WMAX;
        else
            w = SB'(frame_width);
        if (frame_height == '0)
            h = SB'(1);
        else if (SB'(frame_height) > HMAX)
            h = HMAX;
        else
            h = SB'(frame_height);
    end

    assign a_fire   = a_valid_reg && (!a_emit_reg || !q_stat.full);
    assign in_stall = clr_busy_reg || (a_valid_reg && !a_fire);
    assign accept   = in_valid && !in_stall;
    assign clr_busy = clr_busy_reg;

    // classify the incoming item: position, whether it emits, edge masks
    always_comb
    begin
        ic       = (SB'(in_col_reg) >= w) ? '0 : SB'(in_col_reg);
        oc       = (SB'(out_col_reg) >= w) ? '0 : SB'(out_col_reg);
        ic1      = ic + SB'(1);
        oc1      = oc + SB'(1);
        orow1    = SB'(out_row_reg) + SB'(1);
        col_wrap = ic1 >= w;
        out_wrap = oc1 >= w;
        last_row = orow1 >= h;
        pos      = PB'(in_row_reg) * PB'(w) + PB'(ic);
        thresh   = (PB'(w) << 1) + PB'(c2d_pkg::RAD);
        emit     = pos >= thresh;
        done     = emit && out_wrap && last_row;
        for (int r = 0; r < K; r++)
        begin
            tr = (SB + 1)'(out_row_reg) + (SB + 1)'(r);
            tc = (SB + 1)'(oc) + (SB + 1)'(r);
            row_ok[r] = (tr >= (SB + 1)'(c2d_pkg::RAD)) && (tr < (SB + 1)'(h) + (SB + 1)'(c2d_pkg::RAD));
            col_ok[r] = (tc >= (SB + 1)'(c2d_pkg::RAD)) && (tc < (SB + 1)'(w) + (SB + 1)'(c2d_pkg::RAD));
        end

        if (col_wrap)
        begin
            in_col_next = '0;
            in_row_next = (in_row_reg != c2d_pkg::ROW_SAT) ? in_row_reg + 1'b1 : in_row_reg;
        end
        else
        begin
            in_col_next = ic1[CB-1:0];
            in_row_next = in_row_reg;
        end
        out_col_next = oc[CB-1:0];
        out_row_next = out_row_reg;
        if (done)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (emit && out_wrap)
        begin
            out_col_next = '0;
            out_row_next = out_row_reg + 1'b1;
        end
        else if (emit)
        begin
            out_col_next = oc1[CB-1:0];
        end
    end

    // column entering the window and the shifted line store word
    always_comb
    begin
        line = fwd_hit_reg ? fwd_data_reg : ram_q;
        for (int r = 0; r < K - 1; r++)
        begin
            col[r] = line[r*PW +: PW];
        end
        col[K-1] = a_pix_reg;
        for (int r = 0; r < K - 1; r++)
        begin
            line_wr[r*PW +: PW] = col[r+1];
        end
        for (int r = 0; r < K; r++)
        begin
            for (int c = 0; c < K - 1; c++)
            begin
                win_next[r][c] = win_reg[r][c+1];
            end
            win_next[r][K-1] = col[r];
        end
    end

    assign ram_we    = clr_busy_reg || a_fire;
    assign ram_waddr = clr_busy_reg ? clr_cnt_reg : a_addr_reg;
    assign ram_wdata = clr_busy_reg ? '0 : line_wr;

    c2d_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (ic[CB-1:0]),
        .rdata (ram_q)
    );

    assign q_push        = a_fire && a_emit_reg;
    assign q_item.win    = win_next;
    assign q_item.row_ok = a_row_ok_reg;
    assign q_item.col_ok = a_col_ok_reg;
    assign q_item.done   = a_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            a_valid_reg  <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST)
                    clr_busy_reg <= 1'b0;
            end
            if (a_fire)
                win_reg <= win_next;
            if (accept)
            begin
                in_col_reg  <= in_col_next;
                in_row_reg  <= in_row_next;
                out_col_reg <= out_col_next;
                out_row_reg <= out_row_next;
                fwd_hit_reg <= a_fire && (a_addr_reg == ic[CB-1:0]);
            end
            if (accept)
                a_valid_reg <= 1'b1;
            else if (a_fire)
                a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_pix_reg    <= flush ? '0 : pixel_in;
            a_addr_reg   <= ic[CB-1:0];
            a_emit_reg   <= emit;
            a_done_reg   <= done;
            a_row_ok_reg <= row_ok;
            a_col_ok_reg <= col_ok;
            fwd_data_reg <= line_wr;
        end
    end

    a_hold_chk: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !a_fire |=> a_valid_reg)
        else $error("front item lost while waiting for queue space");
    a_push_chk: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("front pushed into a full queue");
    a_clr_chk: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !accept && !a_valid_reg)
        else $error("item taken during line store clearing");

endmodule
`default_nettype wire

// File: rtl/c2d_queue.sv
`default_nettype none
module c2d_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire c2d_pkg::item_t   push_item,
    input  wire logic             pop,
    output c2d_pkg::item_t        head,
    output c2d_pkg::q_stat_t      stat
);

    c2d_pkg::item_t mem_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg;

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = count_reg == 2'd2;
    assign stat.empty = count_reg == 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

// File: rtl/c2d_back.sv
`default_nettype none
module c2d_back (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire c2d_pkg::item_t                      head,
    input  wire c2d_pkg::q_stat_t                    q_stat,
    output logic                                     pop,
    input  wire c2d_pkg::kern_t                      coef,
    input  wire logic [c2d_pkg::SHIFT_BITS-1:0]      result_shift,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [c2d_pkg::PIX_BITS-1:0]             pixel_out,
    output logic                                     frame_done
);

    localparam int K  = c2d_pkg::KSIZE;
    localparam int PB = c2d_pkg::PROD_BITS;
    localparam int RB = c2d_pkg::RSUM_BITS;
    localparam int SB = c2d_pkg::SUM_BITS;

    logic                               en;
    logic                               s1_valid_reg, s2_valid_reg, s3_valid_reg, o_valid_reg;
    logic                               s1_done_reg, s2_done_reg, s3_done_reg, o_done_reg;
    logic signed [K-1:0][K-1:0][PB-1:0] prod, prod_reg;
    logic signed [K-1:0][RB-1:0]        rsum, rsum_reg;
    logic signed [SB-1:0]               total, total_reg;
    logic [SB-1:0]                      shifted;
    logic [c2d_pkg::PIX_BITS-1:0]       clamp, pix_reg;

    assign en  = !o_valid_reg || !out_stall;
    assign pop = en && !q_stat.empty;

    // flipped kernel: window tap (r, c) meets coefficient (K-1-r, K-1-c)
    always_comb
    begin
        for (int r = 0; r < K; r++)
        begin
            for (int c = 0; c < K; c++)
            begin
                if (head.row_ok[r] && head.col_ok[c])
                    prod[r][c] = PB'($signed({1'b0, head.win[r][c]})
                                 * $signed(coef[K-1-r][K-1-c]));
                else
                    prod[r][c] = '0;
            end
        end
    end

    // element selects are unsigned, so sign-extend each term explicitly
    always_comb
    begin
        for (int r = 0; r < K; r++)
        begin
            rsum[r] = '0;
            for (int c = 0; c < K; c++)
            begin
                rsum[r] = rsum[r] + RB'($signed(prod_reg[r][c]));
            end
        end
        total = '0;
        for (int r = 0; r < K; r++)
        begin
            total = total + SB'($signed(rsum_reg[r]));
        end
    end

    // negative or zero sum gives black; otherwise floor-shift and saturate
    always_comb
    begin
        shifted = SB'(total_reg) >> result_shift;
        if (total_reg[SB-1] || total_reg == '0)
            clamp = '0;
        else if (shifted > SB'(c2d_pkg::PIX_MAX))
            clamp = c2d_pkg::PIX_MAX;
        else
            clamp = shifted[c2d_pkg::PIX_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            o_valid_reg  <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= prod;
            s1_done_reg <= head.done;
            rsum_reg    <= rsum;
            s2_done_reg <= s1_done_reg;
            total_reg   <= total;
            s3_done_reg <= s2_done_reg;
            pix_reg     <= clamp;
            o_done_reg  <= s3_done_reg;
        end
    end

    assign out_valid  = o_valid_reg;
    assign pixel_out  = pix_reg;
    assign frame_done = o_done_reg;

endmodule
`default_nettype wire

// File: rtl/conv2d_5x5_clamp_10bit_unit.sv
`default_nettype none
// Path: a request passes through the front stage, queue, products, row sums, total,
// shift and clamp before it reaches the output register.
// Throughput: one request per cycle while in_stall is low; the line store is read and written once per request.
// Reset: after rst_n rises the line store is cleared entry by entry, during
// which in_stall stays high; configuration writes are taken throughout.
module conv2d_5x5_clamp_10bit_unit #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [c2d_pkg::PIX_BITS-1:0]       pixel_in,
    input  wire logic                               flush,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [c2d_pkg::PIX_BITS-1:0]            pixel_out,
    output logic                                    frame_done,
    input  wire logic                               cfg_we,
    input  wire logic [2:0]                         cfg_index,
    input  wire logic [c2d_pkg::CFG_BITS-1:0]       cfg_data
);

    // one bit above the write field so the reset size of 2048 is held
    logic [c2d_pkg::FSIZE_BITS:0]   width_reg, height_reg;
    logic [c2d_pkg::SHIFT_BITS-1:0] shift_reg;
    c2d_pkg::kern_t                 coef_reg;

    logic             q_push, q_pop, clr_busy;
    c2d_pkg::item_t   q_in, q_head;
    c2d_pkg::q_stat_t q_stat;

    // register file: write only, taken whenever the enable is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd2048;
            height_reg <= 13'd2048;
            shift_reg  <= '0;
            coef_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (c2d_pkg::cfg_reg_t'(cfg_index))
                c2d_pkg::REG_WIDTH:  width_reg   <= {1'b0, cfg_data[c2d_pkg::FSIZE_BITS-1:0]};
                c2d_pkg::REG_HEIGHT: height_reg  <= {1'b0, cfg_data[c2d_pkg::FSIZE_BITS-1:0]};
                c2d_pkg::REG_SHIFT:  shift_reg   <= cfg_data[c2d_pkg::SHIFT_BITS-1:0];
                c2d_pkg::REG_COEF0:  coef_reg[0] <= cfg_data;
                c2d_pkg::REG_COEF1:  coef_reg[1] <= cfg_data;
                c2d_pkg::REG_COEF2:  coef_reg[2] <= cfg_data;
                c2d_pkg::REG_COEF3:  coef_reg[3] <= cfg_data;
                c2d_pkg::REG_COEF4:  coef_reg[4] <= cfg_data;
                default:             shift_reg   <= shift_reg;
            endcase
        end
    end

    // front: take requests, track raster position, hold line store and window
    c2d_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_in     (pixel_in),
        .flush        (flush),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .q_stat       (q_stat),
        .q_push       (q_push),
        .q_item       (q_in),
        .clr_busy     (clr_busy)
    );

    // short queue: lets the front run on while the output side is held
    c2d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    // back: multiply, sum, shift and clamp, then hold in the output register
    c2d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .q_stat       (q_stat),
        .pop          (q_pop),
        .coef         (coef_reg),
        .result_shift (shift_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_out    (pixel_out),
        .frame_done   (frame_done)
    );

    t_clr_stall: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> in_stall)
        else $error("request taken while line store clears");
    t_pop_chk: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");
    t_q_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue both full and empty");

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import c2d_pkg::*;

    localparam int MAX_W      = 2048;
    localparam int MAX_H      = 2048;
    localparam int IDLE_LIMIT = 20000;  // covers the line store clearing pass after reset
    localparam int DRAIN_CYC  = 12;     // block latency plus margin
    localparam int RAND_ITEMS = 600;
    localparam int CAP_PIX    = 120;    // pixels sent of an oversized frame

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e             kind;
        cfg_reg_t              cfg_sel;
        logic [CFG_BITS-1:0]   data;
        logic [PIX_BITS-1:0]   pix;
        bit                    fl;
        bit                    typed;
        logic [PIX_BITS-1:0]   e_pix;
        bit                    e_done;
    } stim_row_t;

    typedef struct {
        logic [PIX_BITS-1:0] pix;
        bit                  done;
    } filt_res_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [PIX_BITS-1:0]   pixel_in = '0;
    logic                  flush = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [PIX_BITS-1:0]   pixel_out;
    logic                  frame_done;
    logic                  cfg_we = 1'b0;
    logic [2:0]            cfg_index = '0;
    logic [CFG_BITS-1:0]   cfg_data = '0;

    conv2d_5x5_clamp_10bit_unit #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pixel_in   (pixel_in),
        .flush      (flush),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_out  (pixel_out),
        .frame_done (frame_done),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Shadow copy of the filter: configuration, line buffers, window and counters
    logic [FSIZE_BITS:0]   sh_width  = 13'd2048;
    logic [FSIZE_BITS:0]   sh_height = 13'd2048;
    logic [SHIFT_BITS-1:0] sh_shift  = '0;
    logic [CFG_BITS-1:0]   sh_coef [KSIZE];
    logic [PIX_BITS-1:0]   sh_lines [LINES*MAX_W];
    logic [PIX_BITS-1:0]   sh_win [KSIZE][KSIZE];
    int unsigned           in_col, in_row, out_col, out_row;

    filt_res_t filt_q [$];
    int        fail_cnt = 0;
    int        idle_cnt = 0;
    bit        quiet_in = 1'b0;
    bit        quiet_out = 1'b0;
    int        stall_left = 0;

    // Directed requests: sizes saturating to 1x1, an all-negative kernel, then a mixed kernel.
    // Expected values are typed in only for the zero and negative kernels.
    stim_row_t dir_rows [49] = '{
        '{ROW_CFG,  REG_WIDTH,  60'd0, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_CFG,  REG_HEIGHT, 60'd0, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_CFG,  REG_SHIFT,  60'd0, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_CFG,  REG_COEF0,  60'd0, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_CFG,  REG_COEF1,  60'd0, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_CFG,  REG_COEF2,  60'd0, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_CFG,  REG_COEF3,  60'd0, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_CFG,  REG_COEF4,  60'd0, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd1023, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd0,    1'b1, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd0,    1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd5,    1'b1, 1'b1, 10'd0, 1'b1},
        '{ROW_CFG,  REG_WIDTH,  60'd2, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_CFG,  REG_HEIGHT, 60'd2, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_CFG,  REG_SHIFT,  60'd31, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_CFG,  REG_COEF0,  {60{1'b1}}, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_CFG,  REG_COEF1,  {60{1'b1}}, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_CFG,  REG_COEF2,  {60{1'b1}}, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_CFG,  REG_COEF3,  {60{1'b1}}, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_CFG,  REG_COEF4,  {60{1'b1}}, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd1023, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd0,    1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd512,  1'b1, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd1023, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd0,    1'b1, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd1023, 1'b1, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd0,    1'b1, 1'b1, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd0,    1'b1, 1'b1, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd0,    1'b1, 1'b1, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd0,    1'b1, 1'b1, 10'd0, 1'b1},
        '{ROW_CFG,  REG_WIDTH,  60'd3, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_CFG,  REG_SHIFT,  60'd0, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_CFG,  REG_COEF0,  60'h800_000_000_000_7ff, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_CFG,  REG_COEF2,  60'h000_000_001_000_000, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_CFG,  REG_COEF4,  60'h7ff_7ff_7ff_7ff_7ff, 10'd0, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd1023, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd0,    1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd1,    1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd512,  1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd1023, 1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd341,  1'b0, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd0,    1'b1, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd0,    1'b1, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd0,    1'b1, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd0,    1'b1, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd0,    1'b1, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd0,    1'b1, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd0,    1'b1, 1'b0, 10'd0, 1'b0},
        '{ROW_ITEM, REG_WIDTH,  60'd0, 10'd0,    1'b1, 1'b0, 10'd0, 1'b0}
    };

    function automatic int unsigned clip_size(logic [FSIZE_BITS:0] raw, int unsigned maxv);
        if (raw == 0)
            return 1;
        return (raw > maxv) ? maxv : raw;
    endfunction

    // Advance the shadow filter by one request; return 1 when it yields a pixel
    function automatic bit filter_pixel(input logic [PIX_BITS-1:0] pix_i, input bit fl,
                                        output filt_res_t res);
        int unsigned           w;
        int unsigned           h;
        int unsigned           pos;
        logic [PIX_BITS-1:0]   col [KSIZE];
        logic [COEF_BITS-1:0]  craw;
        longint                acc;
        longint                val;
        int                    py;
        int                    px;
        w = clip_size(sh_width, MAX_W);
        h = clip_size(sh_height, MAX_H);
        res.pix = '0;
        res.done = 1'b0;
        if (in_col >= w)
            in_col = 0;
        if (out_col >= w)
            out_col = 0;
        for (int r = 0; r < LINES; r++)
            col[r] = sh_lines[r*MAX_W + in_col];
        col[KSIZE-1] = fl ? '0 : pix_i;
        for (int r = 0; r < LINES; r++)
            sh_lines[r*MAX_W + in_col] = col[r+1];
        for (int r = 0; r < KSIZE; r++)
        begin
            for (int c = 0; c < KSIZE-1; c++)
                sh_win[r][c] = sh_win[r][c+1];
            sh_win[r][KSIZE-1] = col[r];
        end
        pos = in_row * w + in_col;
        if (in_col + 1 >= w)
        begin
            in_col = 0;
            if (in_row < 4095)
                in_row++;
        end
        else
            in_col++;
        if (pos < RAD * w + RAD)
            return 1'b0;
        acc = 0;
        for (int r = 0; r < KSIZE; r++)
        begin
            py = int'(out_row) + r - RAD;
            if (py < 0 || py >= int'(h))
                continue;
            for (int c = 0; c < KSIZE; c++)
            begin
                px = int'(out_col) + c - RAD;
                if (px < 0 || px >= int'(w))
                    continue;
                // flipped kernel: tap (r, c) uses coefficient (K-1-r, K-1-c)
                craw = sh_coef[KSIZE-1-r][(KSIZE-1-c)*COEF_BITS +: COEF_BITS];
                acc += longint'(sh_win[r][c]) * longint'($signed(craw));
            end
        end
        if (acc <= 0)
            val = 0;
        else
        begin
            val = acc >>> sh_shift;
            if (val > PIX_MAX)
                val = PIX_MAX;
        end
        res.pix = val[PIX_BITS-1:0];
        res.done = (out_col + 1 >= w) && (out_row + 1 >= h);
        if (res.done)
        begin
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
        end
        else if (out_col + 1 >= w)
        begin
            out_col = 0;
            out_row++;
        end
        else
            out_col++;
        return 1'b1;
    endfunction

    function automatic int pick_gap(bit quiet);
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_kernel_row();
        logic [CFG_BITS-1:0]  row;
        logic [COEF_BITS-1:0] k;
        int                   roll;
        for (int c = 0; c < KSIZE; c++)
        begin
            roll = $urandom_range(0, 7);
            if (roll < 2)
                k = '0;
            else if (roll < 6)
                k = COEF_BITS'($urandom_range(0, 16) - 8);
            else if (roll == 6)
                k = $urandom_range(0, 1) ? 12'h7ff : 12'h800;
            else
                k = COEF_BITS'($urandom);
            row[c*COEF_BITS +: COEF_BITS] = k;
        end
        return row;
    endfunction

    // Wait until every expected pixel is out, then let the pipe empty
    task automatic settle();
        while (filt_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    // Present one register write; the caller lowers cfg_we after the last one
    task automatic write_reg(cfg_reg_t sel, logic [CFG_BITS-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= d;
        @(posedge clk);
        case (sel)
            REG_WIDTH:  sh_width  = {1'b0, d[FSIZE_BITS-1:0]};
            REG_HEIGHT: sh_height = {1'b0, d[FSIZE_BITS-1:0]};
            REG_SHIFT:  sh_shift  = d[SHIFT_BITS-1:0];
            default:    sh_coef[sel - REG_COEF0] = d;
        endcase
    endtask

    task automatic write_frame_size(logic [FSIZE_BITS-1:0] w, logic [FSIZE_BITS-1:0] h);
        write_reg(REG_WIDTH,  {48'($urandom), w});
        write_reg(REG_HEIGHT, {48'($urandom), h});
        cfg_we <= 1'b0;
    endtask

    // Offer one request and hold it until the block takes it
    task automatic send_req(logic [PIX_BITS-1:0] p, bit fl, bit typed,
                            filt_res_t typed_res);
        int        gap;
        filt_res_t res;
        gap = pick_gap(quiet_in);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= p;
        flush    <= fl;
        do
            @(posedge clk);
        while (in_stall);
        if (filter_pixel(p, fl, res))
            filt_q.push_back(typed ? typed_res : res);
    endtask

    task automatic send_rand(logic [PIX_BITS-1:0] p, bit fl);
        filt_res_t none;
        none.pix = '0;
        none.done = 1'b0;
        send_req(p, fl, 1'b0, none);
    endtask

    // Output side: check each accepted pixel and draw the next stall
    always @(posedge clk)
    begin
        filt_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (filt_q.size() == 0)
            begin
                $error("unexpected output pixel_out=%0d frame_done=%0d", pixel_out, frame_done);
                fail_cnt++;
            end
            else
            begin
                want = filt_q.pop_front();
                if (pixel_out !== want.pix)
                begin
                    $error("pixel_out: expected %0d, got %0d", want.pix, pixel_out);
                    fail_cnt++;
                end
                if (frame_done !== want.done)
                begin
                    $error("frame_done: expected %0d, got %0d", want.done, frame_done);
                    fail_cnt++;
                end
            end
        end
        if (stall_left > 0)
            stall_left--;
        else
            stall_left = pick_gap(quiet_out);
        out_stall <= (stall_left > 0);
    end

    // Watchdog: count cycles in which neither side moves a request
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT)
        begin
            $display("conv2d_5x5_clamp_10bit_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        int unsigned   sent;
        int unsigned   w;
        int unsigned   h;
        int unsigned   npix;
        int            phase;
        bit            big;
        logic [11:0]   w_raw;
        logic [11:0]   h_raw;
        filt_res_t     tres;

        for (int r = 0; r < KSIZE; r++)
            sh_coef[r] = '0;
        for (int i = 0; i < LINES*MAX_W; i++)
            sh_lines[i] = '0;
        for (int r = 0; r < KSIZE; r++)
            for (int c = 0; c < KSIZE; c++)
                sh_win[r][c] = '0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: settle before each run of register writes
        for (int i = 0; i < $size(dir_rows); i++)
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                if (i == 0 || dir_rows[i-1].kind != ROW_CFG)
                begin
                    in_valid <= 1'b0;
                    settle();
                end
                write_reg(dir_rows[i].cfg_sel, dir_rows[i].data);
            end
            else
            begin
                if (dir_rows[i-1].kind == ROW_CFG)
                    cfg_we <= 1'b0;
                tres.pix  = dir_rows[i].e_pix;
                tres.done = dir_rows[i].e_done;
                send_req(dir_rows[i].pix, dir_rows[i].fl, dir_rows[i].typed, tres);
            end
        end

        // Random part: one configuration per phase, one to three frames each
        sent = 0;
        phase = 0;
        while (sent < RAND_ITEMS)
        begin
            in_valid <= 1'b0;
            settle();       // hold the sender until the pipe is empty
            quiet_in  = ($urandom_range(0, 3) == 0);
            quiet_out = ($urandom_range(0, 3) == 0);
            if (phase == 1)
            begin
                w_raw = 12'hfff;    // saturates to the widest row
                h_raw = 12'd1;
            end
            else if (phase == 3)
            begin
                w_raw = 12'd1;
                h_raw = 12'hfff;    // saturates to the tallest frame
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                w_raw = 12'd0;
                h_raw = $urandom_range(0, 1) ? 12'd0 : 12'($urandom_range(1, 4));
            end
            else
            begin
                w_raw = 12'($urandom_range(1, 8));
                h_raw = 12'($urandom_range(1, 6));
            end
            write_reg(REG_WIDTH,  {48'($urandom), w_raw});
            write_reg(REG_HEIGHT, {48'($urandom), h_raw});
            write_reg(REG_SHIFT,  {55'($urandom),
                ($urandom_range(0, 7) == 0) ? 5'd31 : 5'($urandom_range(0, 10))});
            for (int r = 0; r < KSIZE; r++)
                write_reg(cfg_reg_t'(REG_COEF0 + r), pick_kernel_row());
            cfg_we <= 1'b0;
            w = clip_size({1'b0, w_raw}, MAX_W);
            h = clip_size({1'b0, h_raw}, MAX_H);

            repeat ($urandom_range(1, 3))
            begin
                npix = w * h;
                big = (npix > CAP_PIX);
                // oversized frame: send only its start, then shrink it to end it
                if (big)
                    npix = CAP_PIX;
                for (int unsigned k = 0; k < npix; k++)
                begin
                    // shrink the frame mid-way now and then
                    if (k == npix / 2 && npix > 4 && w < 64 && $urandom_range(0, 4) == 0)
                    begin
                        in_valid <= 1'b0;
                        settle();
                        w = $urandom_range(1, w);
                        h = $urandom_range(1, h);
                        write_frame_size(12'(w), 12'(h));
                    end
                    // noise: an odd flush request inside the frame
                    send_rand(PIX_BITS'($urandom), ($urandom_range(0, 15) == 0));
                    sent++;
                end
                if (big)
                begin
                    in_valid <= 1'b0;
                    settle();
                    w = $urandom_range(1, 8);
                    h = $urandom_range(1, 4);
                    write_frame_size(12'(w), 12'(h));
                end
                // broken frame: a stray pixel past the end
                if ($urandom_range(0, 7) == 0)
                begin
                    send_rand(PIX_BITS'($urandom), 1'b0);
                    sent++;
                end
                for (int unsigned k = 0; k < 2*w + 2; k++)
                begin
                    send_rand(PIX_BITS'($urandom), 1'b1);
                    sent++;
                end
            end
            phase++;
        end

        in_valid <= 1'b0;
        settle();
        if (fail_cnt == 0)
            $display("conv2d_5x5_clamp_10bit_unit regression: pass");
        else
            $display("conv2d_5x5_clamp_10bit_unit regression: fail");
        $finish;
    end

endmodule

// File: conv2d_5x5_clamp_10bit_unit.f
rtl/c2d_pkg.sv
rtl/c2d_ram.sv
rtl/c2d_front.sv
rtl/c2d_queue.sv
rtl/c2d_back.sv
rtl/conv2d_5x5_clamp_10bit_unit.sv
tb/sv/tb.sv
